// ===== sv/leapfrog_multistream_lcg_defines.svh =====
`ifndef LEAPFROG_MULTISTREAM_LCG_DEFINES_SVH
`define LEAPFROG_MULTISTREAM_LCG_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and held off during reset.
`define LML_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and held off during reset.
`define LML_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lml_pkg.sv =====
`timescale 1ns / 1ps

package lml_pkg;

    localparam int          MAX_STREAMS_DEF = 64;
    localparam logic [30:0] LCG_MULT        = 31'd764261123;
    localparam logic [31:0] LCG_MOD         = 32'd2147483647;

    typedef struct packed {
        logic        mode;
        logic [5:0]  stream_index;
        logic        reread;
        logic [63:0] seed_value;
        logic [6:0]  stream_count;
    } t_in_item;

    typedef struct packed {
        logic [30:0] random_value;
        logic        status;
        logic [6:0]  seeded_count;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAW_READ,
        ST_DRAW_MUL,
        ST_DRAW_RED,
        ST_SEED_FOLD,
        ST_SEED_RED,
        ST_SEED_WRITE,
        ST_SEED_STEP,
        ST_EMIT
    } t_state;

    // Reduces a product of two residues modulo 2^31-1, using 2^31 = 1 (mod P).
    function automatic logic [30:0] mersenne_reduce(input logic [61:0] p);
        logic [31:0] s;
        logic [31:0] t;
        s = {1'b0, p[61:31]} + {1'b0, p[30:0]};
        t = {1'b0, s[30:0]} + {31'b0, s[31]};
        mersenne_reduce = (t >= LCG_MOD) ? 31'(t - LCG_MOD) : t[30:0];
    endfunction

endpackage

// ===== sv/leapfrog_multistream_lcg.sv =====
`timescale 1ns / 1ps
`include "leapfrog_multistream_lcg_defines.svh"

// Multi-stream leapfrog Lehmer generator modulo 2^31-1 (multiplier 764261123).
// Stream values live in a one-port-write, registered-read memory. Items are
// handled one at a time: an advancing draw passes read, multiply, reduce
// and write back, then result; a reread goes from read to result, a refused
// item straight to result, and a reseed of T streams loops a multiply/reduce
// step that writes one stream entry per pass. A finished result waits in the
// output register, so the next transaction can be taken while it is still stalled.
module leapfrog_multistream_lcg #(
    parameter int MAX_STREAMS = lml_pkg::MAX_STREAMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lml_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lml_pkg::t_out_item o_out_data
);
    import lml_pkg::*;

    localparam int AW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

    t_state      r_state, n_state;
    logic [6:0]  r_active;
    logic [30:0] r_step;
    logic        r_ovalid;
    t_out_item   r_out;

    t_out_item   r_res;
    logic        r_reread;
    logic [AW-1:0] r_addr;
    logic [63:0] r_seed;
    logic [32:0] r_sum;
    logic [6:0]  r_cnt;
    logic [6:0]  r_k;
    logic [30:0] r_v;
    logic [30:0] r_mk;
    logic [61:0] r_pv;
    logic [61:0] r_pm;
    logic [30:0] r_rdata;

    logic [30:0] mem [MAX_STREAMS];

    logic          in_accept;
    logic          in_err;
    logic          out_free;
    logic          seed_last;
    logic [6:0]    cnt_sat;
    logic [AW+5:0] idx_ext;
    logic [AW+6:0] k_ext;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [30:0]   wdata;
    logic          mem_we;
    logic [31:0]   seed_fold;
    logic [30:0]   seed_res;
    logic [30:0]   draw_res;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_ovalid || !i_out_stall;
    assign seed_last = (r_k + 7'd1) == r_cnt;
    assign idx_ext   = {{AW{1'b0}}, i_in_data.stream_index};
    assign k_ext     = {{AW{1'b0}}, r_k};
    assign raddr     = idx_ext[AW-1:0];

    always_comb begin
        if (int'(i_in_data.stream_count) > MAX_STREAMS) begin
            cnt_sat = 7'(MAX_STREAMS);
        end else begin
            cnt_sat = i_in_data.stream_count;
        end
        if (i_in_data.mode) begin
            in_err = (i_in_data.stream_count == 7'd0);
        end else begin
            in_err = (r_active == 7'd0) || ({1'b0, i_in_data.stream_index} >= r_active);
        end
    end

    // Fold the seed's two 31-bit digits and its top two bits, then a final correction.
    assign seed_fold = {1'b0, r_sum[30:0]} + {30'b0, r_sum[32:31]};
    assign seed_res  = (seed_fold >= LCG_MOD) ? 31'(seed_fold - LCG_MOD) : seed_fold[30:0];
    assign draw_res  = mersenne_reduce(r_pv);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_err) begin
                        n_state = ST_EMIT;
                    end else if (i_in_data.mode) begin
                        n_state = ST_SEED_FOLD;
                    end else begin
                        n_state = ST_DRAW_READ;
                    end
                end
            end
            ST_DRAW_READ:  n_state = r_reread ? ST_EMIT : ST_DRAW_MUL;
            ST_DRAW_MUL:   n_state = ST_DRAW_RED;
            ST_DRAW_RED:   n_state = ST_EMIT;
            ST_SEED_FOLD:  n_state = ST_SEED_RED;
            ST_SEED_RED:   n_state = ST_SEED_WRITE;
            ST_SEED_WRITE: n_state = ST_SEED_STEP;
            ST_SEED_STEP:  n_state = seed_last ? ST_EMIT : ST_SEED_WRITE;
            ST_EMIT:       n_state = out_free ? ST_IDLE : ST_EMIT;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        mem_we     = 1'b0;
        waddr      = r_addr;
        wdata      = draw_res;
        unique case (r_state)
            ST_DRAW_RED: begin
                mem_we = 1'b1;
            end
            ST_SEED_WRITE: begin
                mem_we = 1'b1;
                waddr  = k_ext[AW-1:0];
                wdata  = r_v;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= 7'd0;
            r_step   <= LCG_MULT;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SEED_STEP && seed_last) begin
                r_step   <= mersenne_reduce(r_pm);
                r_active <= r_cnt;
            end
            if (r_state == ST_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_reread <= i_in_data.reread;
                r_addr   <= raddr;
                r_seed   <= i_in_data.seed_value;
                r_cnt    <= cnt_sat;
                r_res    <= '{random_value: 31'd0, status: in_err, seeded_count: 7'd0};
            end
            ST_DRAW_READ: begin
                r_res.random_value <= r_rdata;
                r_pv <= {31'b0, r_rdata} * {31'b0, r_step};
            end
            ST_DRAW_RED: begin
                r_res.random_value <= draw_res;
            end
            ST_SEED_FOLD: begin
                r_sum <= {2'b0, r_seed[30:0]} + {2'b0, r_seed[61:31]}
                       + {31'b0, r_seed[63:62]};
            end
            ST_SEED_RED: begin
                r_v  <= seed_res;
                r_mk <= 31'd1;
                r_k  <= 7'd0;
            end
            ST_SEED_WRITE: begin
                r_pv <= {31'b0, r_v} * {31'b0, LCG_MULT};
                r_pm <= {31'b0, r_mk} * {31'b0, LCG_MULT};
            end
            ST_SEED_STEP: begin
                r_v  <= draw_res;
                r_mk <= mersenne_reduce(r_pm);
                r_k  <= r_k + 7'd1;
                r_res.seeded_count <= r_cnt;
            end
            ST_EMIT: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `LML_ASSERT_NOW(a_active_range, 1'b1, int'(r_active) <= MAX_STREAMS, "active stream count exceeds depth")
    `LML_ASSERT_NOW(a_value_residue, o_out_valid, r_out.random_value != 31'h7fffffff, "result is not a residue")
    `LML_ASSERT_NOW(a_error_clean, o_out_valid && r_out.status, r_out.random_value == 31'd0 && r_out.seeded_count == 7'd0, "error result carries data")
    `LML_ASSERT_NOW(a_seed_index, r_state == ST_SEED_WRITE, r_k < r_cnt, "seed write beyond stream count")
    `LML_ASSERT_NEXT(a_seed_commit, r_state == ST_SEED_STEP && seed_last, r_active == r_res.seeded_count && r_state == ST_EMIT, "reseed did not commit its stream count")

endmodule

// ===== tb/sv/lml_tb_pkg.sv =====
`timescale 1ns / 1ps

package lml_tb_pkg;

    localparam logic MODE_DRAW   = 1'b0;
    localparam logic MODE_RESEED = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_MISS = 1'b1;

endpackage

// ===== tb/sv/leapfrog_multistream_lcg_checker.sv =====
`timescale 1ns / 1ps

module leapfrog_multistream_lcg_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  lml_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  lml_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import lml_pkg::*;
    import lml_tb_pkg::*;

    logic [30:0] lane_value [MAX_STREAMS_DEF];
    logic [30:0] leap_mult;
    int unsigned lanes_live;
    int          fails;
    t_out_item   draws_due_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fails        = 0;
        leap_mult    = LCG_MULT;
        lanes_live   = 0;
    end

    function automatic logic [30:0] lehmer_mulmod(input logic [30:0] a, input logic [30:0] b);
        logic [63:0] prod;
        prod = 64'(a) * 64'(b);
        return 31'(prod % 64'(LCG_MOD));
    endfunction

    // Applies one transaction to the shadow streams and returns its result.
    function automatic t_out_item lehmer_predict(input t_in_item it);
        t_out_item   r;
        logic [30:0] v;
        logic [30:0] mk;
        int unsigned cnt;
        int unsigned k;
        r = '0;
        if (it.mode == MODE_RESEED) begin
            if (it.stream_count == 7'd0) begin
                r.status = STATUS_MISS;
                return r;
            end
            cnt = (it.stream_count > MAX_STREAMS_DEF) ? MAX_STREAMS_DEF : it.stream_count;
            v   = 31'(it.seed_value % 64'(LCG_MOD));
            mk  = 31'd1;
            for (k = 0; k < cnt; k++) begin
                lane_value[k] = v;
                v  = lehmer_mulmod(v, LCG_MULT);
                mk = lehmer_mulmod(mk, LCG_MULT);
            end
            leap_mult       = mk;
            lanes_live      = cnt;
            r.seeded_count  = 7'(cnt);
            return r;
        end
        if (lanes_live == 0 || it.stream_index >= lanes_live) begin
            r.status = STATUS_MISS;
            return r;
        end
        if (!it.reread)
            lane_value[it.stream_index] = lehmer_mulmod(lane_value[it.stream_index], leap_mult);
        r.random_value = lane_value[it.stream_index];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            leap_mult  = LCG_MULT;
            lanes_live = 0;
            draws_due_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                draws_due_q.push_back(lehmer_predict(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (draws_due_q.size() == 0) begin
                    $error("result transaction with nothing expected: %p", i_out_data);
                    fails++;
                end else begin
                    want = draws_due_q.pop_front();
                    if (i_out_data.random_value !== want.random_value) begin
                        $error("random_value: expected %0d, got %0d",
                               want.random_value, i_out_data.random_value);
                        fails++;
                    end
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, i_out_data.status);
                        fails++;
                    end
                    if (i_out_data.seeded_count !== want.seeded_count) begin
                        $error("seeded_count: expected %0d, got %0d",
                               want.seeded_count, i_out_data.seeded_count);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= draws_due_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/sv/leapfrog_multistream_lcg_tb.sv =====
`timescale 1ns / 1ps

module leapfrog_multistream_lcg_tb;
    import lml_pkg::*;
    import lml_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    int chk_fails;
    int chk_pending;
    int cycle_count  = 0;
    int live_streams = 0;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;

    always #2 i_clk = ~i_clk;

    leapfrog_multistream_lcg u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    leapfrog_multistream_lcg_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending)
    );

    function automatic logic [63:0] rand_word64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item build_item(input logic mode, input logic [5:0] idx,
                                            input logic rr, input logic [63:0] seed,
                                            input logic [6:0] cnt);
        t_in_item it;
        it.mode         = mode;
        it.stream_index = idx;
        it.reread       = rr;
        it.seed_value   = seed;
        it.stream_count = cnt;
        return it;
    endfunction

    // Mostly draws from live streams, with occasional reseeds and stray indexes.
    function automatic t_in_item random_item();
        logic [63:0] seed;
        logic [6:0]  cnt;
        logic [5:0]  idx;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            pick = $urandom_range(99);
            if (pick < 70)
                cnt = 7'($urandom_range(8, 1));
            else if (pick < 85)
                cnt = 7'($urandom_range(64, 9));
            else if (pick < 95)
                cnt = 7'($urandom_range(127, 65));
            else
                cnt = 7'd0;
            if ($urandom_range(9) == 0)
                seed = 64'(LCG_MOD) * 64'($urandom_range(1000));
            else
                seed = rand_word64();
            if (cnt != 7'd0)
                live_streams = (cnt > MAX_STREAMS_DEF) ? MAX_STREAMS_DEF : cnt;
            return build_item(MODE_RESEED, 6'($urandom), 1'($urandom), seed, cnt);
        end
        if (live_streams > 0 && $urandom_range(99) < 85)
            idx = 6'($urandom_range(live_streams - 1));
        else
            idx = 6'($urandom);
        return build_item(MODE_DRAW, idx, ($urandom_range(99) < 20), rand_word64(),
                          7'($urandom));
    endfunction

    task automatic send_item(input t_in_item it);
        while (!calm && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Result side: random stalls, a quiet stretch, and one long hold-off.
    initial begin : result_side
        int  hold_left = 0;
        bit  hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < 38);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Draws and a refused reseed on an unseeded block.
        send_item(build_item(MODE_DRAW, 6'd0, 1'b0, rand_word64(), 7'd5));
        send_item(build_item(MODE_DRAW, 6'd63, 1'b1, rand_word64(), 7'd127));
        send_item(build_item(MODE_RESEED, 6'd0, 1'b0, rand_word64(), 7'd0));
        send_item(build_item(MODE_DRAW, 6'd0, 1'b0, '0, 7'd0));
        // Single stream from the largest seed; a neighbor index is unknown.
        send_item(build_item(MODE_RESEED, 6'd0, 1'b0, '1, 7'd1));
        send_item(build_item(MODE_DRAW, 6'd0, 1'b0, '0, 7'd0));
        send_item(build_item(MODE_DRAW, 6'd1, 1'b0, '0, 7'd0));
        send_item(build_item(MODE_DRAW, 6'd0, 1'b1, '0, 7'd0));
        // A seed equal to the modulus collapses every stream to zero.
        send_item(build_item(MODE_RESEED, 6'd0, 1'b0, 64'(LCG_MOD), 7'd3));
        send_item(build_item(MODE_DRAW, 6'd2, 1'b0, '0, 7'd0));
        send_item(build_item(MODE_DRAW, 6'd2, 1'b1, '0, 7'd0));
        // Oversized counts saturate to the full table.
        send_item(build_item(MODE_RESEED, 6'd63, 1'b1, 64'(LCG_MOD) - 64'd1, 7'd127));
        send_item(build_item(MODE_DRAW, 6'd63, 1'b0, '0, 7'd0));
        send_item(build_item(MODE_DRAW, 6'd63, 1'b1, '0, 7'd0));
        send_item(build_item(MODE_DRAW, 6'd0, 1'b0, '0, 7'd0));
        // A refused reseed must leave the 64 streams in place.
        send_item(build_item(MODE_RESEED, 6'd0, 1'b0, 64'd12345, 7'd0));
        send_item(build_item(MODE_DRAW, 6'd63, 1'b0, '0, 7'd0));
        send_item(build_item(MODE_RESEED, 6'd0, 1'b0, 64'd1, 7'd64));
        send_item(build_item(MODE_DRAW, 6'd0, 1'b0, '0, 7'd0));
        send_item(build_item(MODE_RESEED, 6'd0, 1'b0, 64'd0, 7'd65));
        send_item(build_item(MODE_DRAW, 6'd10, 1'b0, '0, 7'd0));
        send_item(build_item(MODE_RESEED, 6'd0, 1'b0, rand_word64(), 7'd2));
        send_item(build_item(MODE_DRAW, 6'd2, 1'b0, '0, 7'd0));
        send_item(build_item(MODE_DRAW, 6'd1, 1'b0, '0, 7'd0));
        live_streams = 2;

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 400 && n < 600);
            if (n == 800)
                hold_request = 1'b1;
            if (n == 1000) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (chk_pending != 0);
            end
            send_item(random_item());
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (chk_pending != 0);
        repeat (150) @(posedge i_clk);
        if (chk_fails == 0 && chk_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
